@@ rtl/hcfp_pkg.sv @@
// Package for the host command frame parser.
// Holds frame constants, event codes and the word types of both channels.
// No dependencies.
`default_nettype none

package hcfp_pkg;

  localparam int unsigned FRAME_LEN = 200;

  localparam logic [7:0] SYNC_BYTE = 8'h7E;
  localparam logic [7:0] TYPE_CMD  = 8'hCD;
  localparam logic [7:0] TYPE_DATA = 8'hDA;

  localparam logic [7:0] CMD_INIT_B0 = 8'h09;
  localparam logic [7:0] CMD_INIT_B1 = 8'hD2;
  localparam logic [7:0] CMD_BIND_B0 = 8'h04;
  localparam logic [7:0] CMD_BIND_B1 = 8'hCD;
  localparam logic [7:0] CMD_PAGE_B1 = 8'hCA;

  localparam logic [7:0] POS_TYPE  = 8'd2;
  localparam logic [7:0] POS_CMD0  = 8'd3;
  localparam logic [7:0] POS_LAST  = 8'(FRAME_LEN - 1);

  typedef logic [2:0] event_t;

  localparam event_t EV_NONE    = 3'd0;
  localparam event_t EV_INIT    = 3'd1;
  localparam event_t EV_BIND    = 3'd2;
  localparam event_t EV_PAGE    = 3'd3;
  localparam event_t EV_UNKNOWN = 3'd4;
  localparam event_t EV_DONE    = 3'd5;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_word_t;

  typedef struct packed {
    event_t     event_res;
    logic [7:0] page_number;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_sum;
  } res_word_t;

endpackage

`default_nettype wire

@@ rtl/hcfp_stream_if.sv @@
// Valid/ready stream interface used by both parser channels.
// Word type is a parameter; the parser uses the word types of hcfp_pkg.
`default_nettype none

interface hcfp_stream_if #(
  parameter type payload_t = logic [7:0]
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

@@ rtl/host_command_frame_parser_core.sv @@
// Host command frame parser: top level, frame state and result register.
// Depends on hcfp_pkg and hcfp_stream_if.
//
// Channel  Dir  Word                 Meaning
// rx       in   hcfp_pkg::rx_word_t  one received byte
// res      out  hcfp_pkg::res_word_t one result per received byte
// cfg      in   cfg_we / cfg_wdata   rx_enable register
//
// For every byte, the frame state updates and the result register
// loads at the edge that accepts it. A new byte is taken every cycle while the
// result register is empty or being drained in the same cycle. Synchronous
// reset clears the enable, count, frame type, sum and result valid. A stalled
// result holds the register and backpressures rx.
`default_nettype none

module host_command_frame_parser_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic          cfg_wdata,
  hcfp_stream_if.sink        rx,
  hcfp_stream_if.source      res
);

  logic                rx_enable;
  logic [7:0]          byte_count;
  logic [7:0]          byte_count_next;
  logic                is_data_frame;
  logic                is_data_frame_next;
  logic [7:0]          first_cmd;
  logic [7:0]          running_sum;
  logic [7:0]          running_sum_next;
  logic                res_valid;
  hcfp_pkg::res_word_t res_word;
  hcfp_pkg::res_word_t res_word_next;
  logic                rx_accept;
  logic [7:0]          b;

  assign b         = rx.payload.rx_byte;
  assign rx.ready  = !res_valid || res.ready;
  assign rx_accept = rx.valid && rx.ready;
  assign res.valid   = res_valid;
  assign res.payload = res_word;

  always_comb begin
    byte_count_next    = byte_count;
    is_data_frame_next = is_data_frame;
    running_sum_next   = running_sum;
    res_word_next      = '0;
    res_word_next.event_res = hcfp_pkg::EV_NONE;
    if (rx_enable) begin
      priority if (byte_count < hcfp_pkg::POS_TYPE) begin
        if (b == hcfp_pkg::SYNC_BYTE) begin
          byte_count_next  = byte_count + 8'd1;
          running_sum_next = running_sum + b;
        end else begin
          byte_count_next  = '0;
          running_sum_next = '0;
        end
      end else if (byte_count == hcfp_pkg::POS_TYPE) begin
        if (b == hcfp_pkg::TYPE_CMD || b == hcfp_pkg::TYPE_DATA) begin
          is_data_frame_next = (b == hcfp_pkg::TYPE_DATA);
          byte_count_next    = hcfp_pkg::POS_CMD0;
          running_sum_next   = running_sum + b;
        end else begin
          byte_count_next  = '0;
          running_sum_next = '0;
        end
      end else if (!is_data_frame) begin
        if (byte_count == hcfp_pkg::POS_CMD0) begin
          byte_count_next = byte_count + 8'd1;
        end else begin
          priority if (first_cmd == hcfp_pkg::CMD_INIT_B0 && b == hcfp_pkg::CMD_INIT_B1) begin
            res_word_next.event_res = hcfp_pkg::EV_INIT;
          end else if (first_cmd == hcfp_pkg::CMD_BIND_B0
                       && b == hcfp_pkg::CMD_BIND_B1) begin
            res_word_next.event_res = hcfp_pkg::EV_BIND;
          end else if (b == hcfp_pkg::CMD_PAGE_B1) begin
            res_word_next.event_res   = hcfp_pkg::EV_PAGE;
            res_word_next.page_number = first_cmd;
          end else begin
            res_word_next.event_res = hcfp_pkg::EV_UNKNOWN;
          end
          byte_count_next  = '0;
          running_sum_next = '0;
        end
      end else begin
        res_word_next.payload_valid = 1'b1;
        res_word_next.payload_byte  = b;
        res_word_next.payload_index = byte_count;
        if (byte_count >= hcfp_pkg::POS_LAST) begin
          res_word_next.event_res = hcfp_pkg::EV_DONE;
          res_word_next.frame_sum = running_sum;
          byte_count_next  = '0;
          running_sum_next = '0;
        end else begin
          byte_count_next  = byte_count + 8'd1;
          running_sum_next = running_sum + b;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_enable     <= 1'b0;
      byte_count    <= '0;
      is_data_frame <= 1'b0;
      running_sum   <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        rx_enable <= cfg_wdata;
      end
      if (rx_accept) begin
        byte_count    <= byte_count_next;
        is_data_frame <= is_data_frame_next;
        running_sum   <= running_sum_next;
        res_valid     <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx_accept) begin
      res_word <= res_word_next;
    end
    if (rx_accept && rx_enable && !is_data_frame && byte_count == hcfp_pkg::POS_CMD0) begin
      first_cmd <= b;
    end
  end

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    rx_accept |=> res_valid)
    else $error("accepted byte produced no result");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= hcfp_pkg::POS_LAST)
    else $error("byte count ran past frame end");

  a_done_payload: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_word.event_res == hcfp_pkg::EV_DONE
    |-> res_word.payload_valid && res_word.payload_index == hcfp_pkg::POS_LAST)
    else $error("frame done without last payload byte");

  a_cmd_no_payload: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_word.event_res != hcfp_pkg::EV_NONE
    && res_word.event_res != hcfp_pkg::EV_DONE |-> !res_word.payload_valid)
    else $error("command event with payload byte");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_word.payload_valid
    |-> res_word.payload_index >= hcfp_pkg::POS_CMD0
        && res_word.payload_index <= hcfp_pkg::POS_LAST)
    else $error("payload index out of range");

endmodule

`default_nettype wire
